>>> rtl/typed_priority_job_dispatcher_top_defines.svh
// assertion macros for the job dispatcher
`ifndef TYPED_PRIORITY_JOB_DISPATCHER_TOP_DEFINES_SVH
`define TYPED_PRIORITY_JOB_DISPATCHER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TPJD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TPJD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TPJD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TPJD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/tpjd_pkg.sv
// shared types and codes of the job dispatcher
package tpjd_pkg;
    localparam logic [1:0] KIND_SUBMIT  = 2'd0;
    localparam logic [1:0] KIND_TICK    = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    localparam logic [1:0] PRIO_LOW    = 2'd0;
    localparam logic [1:0] PRIO_NORMAL = 2'd1;
    localparam logic [1:0] PRIO_HIGH   = 2'd2;

    localparam logic [2:0] ST_DISPATCHED = 3'd0;
    localparam logic [2:0] ST_QUEUED     = 3'd1;
    localparam logic [2:0] ST_DROPPED    = 3'd2;
    localparam logic [2:0] ST_TICK_DONE  = 3'd3;
    localparam logic [2:0] ST_RELEASED   = 3'd4;
    localparam logic [2:0] ST_IGNORED    = 3'd5;

    localparam logic [1:0] Q_LOW    = 2'd0;
    localparam logic [1:0] Q_NORMAL = 2'd1;
    localparam logic [1:0] Q_HIGH   = 2'd2;

    localparam logic CFG_WORKER_COUNT = 1'b0;
    localparam logic CFG_TYPE_MASKS   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUBMIT,
        S_RD,
        S_WAIT,
        S_HEAD,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       load;      // capture input word
        logic       match_in;  // run worker match on input type
        logic       push;      // push input word to selected queue
        logic       rd;        // start read of queue head
        logic       pop;       // dispatch head
        logic       grant_in;  // dispatch input word directly
        logic       release_w; // free worker
        logic [1:0] qsel;      // queue in use
        logic       emit;      // present a result
        logic [2:0] status;
        logic       use_worker;
        logic       use_tag;
        logic       use_head;
        logic       last;
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] prio;
        logic       found;     // a matching idle worker exists
        logic       q_empty;
        logic       q_full;
        logic       rel_ok;
    } t_stat;
endpackage

>>> rtl/tpjd_ctrl.sv
// controller state machine of the job dispatcher
module tpjd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_kind,
    input  tpjd_pkg::t_stat  i_stat,
    output tpjd_pkg::t_ctrl  o_ctrl,
    output logic             o_busy
);
    tpjd_pkg::t_state r_state, n_state;
    logic [1:0] r_q, n_q;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpjd_pkg::S_IDLE;
            r_q     <= tpjd_pkg::Q_HIGH;
        end else begin
            r_state <= n_state;
            r_q     <= n_q;
        end
    end

    assign o_busy = (r_state != tpjd_pkg::S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_q     = r_q;
        o_ctrl  = '0;
        o_ctrl.qsel = r_q;
        unique case (r_state)
            tpjd_pkg::S_IDLE: begin
                if (i_start) begin
                    o_ctrl.load = 1'b1;
                    if (i_kind == tpjd_pkg::KIND_SUBMIT) begin
                        n_state = tpjd_pkg::S_SUBMIT;
                    end else if (i_kind == tpjd_pkg::KIND_TICK) begin
                        n_q = tpjd_pkg::Q_HIGH;
                        n_state = tpjd_pkg::S_RD;
                    end else if (i_kind == tpjd_pkg::KIND_RELEASE) begin
                        n_state = tpjd_pkg::S_DONE;
                    end
                end
            end
            tpjd_pkg::S_SUBMIT: begin
                o_ctrl.match_in = 1'b1;
                o_ctrl.emit = 1'b1;
                o_ctrl.last = 1'b1;
                o_ctrl.use_tag = 1'b1;
                o_ctrl.qsel = (i_stat.prio == tpjd_pkg::PRIO_HIGH) ? tpjd_pkg::Q_HIGH :
                              (i_stat.prio == tpjd_pkg::PRIO_LOW) ? tpjd_pkg::Q_LOW :
                              tpjd_pkg::Q_NORMAL;
                n_state = tpjd_pkg::S_IDLE;
                if (i_stat.prio == tpjd_pkg::PRIO_HIGH && i_stat.found) begin
                    o_ctrl.grant_in = 1'b1;
                    o_ctrl.use_worker = 1'b1;
                    o_ctrl.status = tpjd_pkg::ST_DISPATCHED;
                end else if (i_stat.q_full) begin
                    o_ctrl.status = tpjd_pkg::ST_DROPPED;
                end else begin
                    o_ctrl.push = 1'b1;
                    o_ctrl.status = tpjd_pkg::ST_QUEUED;
                end
            end
            tpjd_pkg::S_RD: begin
                if (i_stat.q_empty) begin
                    if (r_q == tpjd_pkg::Q_LOW) begin
                        n_state = tpjd_pkg::S_DONE;
                    end else begin
                        n_q = r_q - 2'd1;
                    end
                end else begin
                    o_ctrl.rd = 1'b1;
                    n_state = tpjd_pkg::S_WAIT;
                end
            end
            tpjd_pkg::S_WAIT: begin
                n_state = tpjd_pkg::S_HEAD;
            end
            tpjd_pkg::S_HEAD: begin
                n_state = tpjd_pkg::S_RD;
                if (i_stat.found) begin
                    o_ctrl.pop = 1'b1;
                    o_ctrl.emit = 1'b1;
                    o_ctrl.use_worker = 1'b1;
                    o_ctrl.use_head = 1'b1;
                    o_ctrl.use_tag = 1'b1;
                    o_ctrl.status = tpjd_pkg::ST_DISPATCHED;
                end else if (r_q == tpjd_pkg::Q_LOW) begin
                    n_state = tpjd_pkg::S_DONE;
                end else begin
                    n_q = r_q - 2'd1;
                end
            end
            tpjd_pkg::S_DONE: begin
                o_ctrl.emit = 1'b1;
                o_ctrl.last = 1'b1;
                n_state = tpjd_pkg::S_IDLE;
                if (i_stat.kind == tpjd_pkg::KIND_RELEASE) begin
                    o_ctrl.use_worker = 1'b1;
                    if (i_stat.rel_ok) begin
                        o_ctrl.release_w = 1'b1;
                        o_ctrl.status = tpjd_pkg::ST_RELEASED;
                    end else begin
                        o_ctrl.status = tpjd_pkg::ST_IGNORED;
                    end
                end else begin
                    o_ctrl.status = tpjd_pkg::ST_TICK_DONE;
                end
            end
            default: n_state = tpjd_pkg::S_IDLE;
        endcase
    end
endmodule

>>> rtl/tpjd_datapath.sv
// queues, worker state and result register of the job dispatcher
module tpjd_datapath #(
    parameter int QUEUE_DEPTH = 1024,
    parameter int WORKERS     = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [63:0]      i_cfg_data,
    input  logic [1:0]       i_kind,
    input  logic [15:0]      i_job_tag,
    input  logic [7:0]       i_job_type,
    input  logic [1:0]       i_priority_req,
    input  logic [2:0]       i_worker,
    input  tpjd_pkg::t_ctrl  i_ctrl,
    output tpjd_pkg::t_stat  o_stat,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic [2:0]       o_assigned_worker,
    output logic [15:0]      o_dispatched_tag,
    output logic             o_last
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [3:0]  r_wcount;
    logic [63:0] r_masks;
    logic [WORKERS-1:0] r_busy;
    logic [1:0]  r_kind, r_prio;
    logic [15:0] r_tag;
    logic [7:0]  r_type;
    logic [2:0]  r_wk;

    // queue memories and pointers
    logic [23:0] r_mem_h [QUEUE_DEPTH];
    logic [23:0] r_mem_n [QUEUE_DEPTH];
    logic [23:0] r_mem_l [QUEUE_DEPTH];
    logic [AW-1:0] r_head [3];
    logic [CW-1:0] r_cnt  [3];
    logic [23:0] r_rd_h, r_rd_n, r_rd_l;
    logic [23:0] head_word;
    logic [AW-1:0] wr_pos;
    logic [AW:0]   wr_sum;
    logic [7:0]  mtype;
    logic [WORKERS-1:0] cand;
    logic [2:0]  win;
    logic        found;
    logic [3:0]  active;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcount <= 4'd8;
            r_masks  <= '1;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == tpjd_pkg::CFG_WORKER_COUNT) r_wcount <= i_cfg_data[3:0];
            else r_masks <= i_cfg_data;
        end
    end

    // captured input word
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_kind <= i_kind;
            r_tag  <= i_job_tag;
            r_type <= i_job_type;
            r_prio <= i_priority_req;
            r_wk   <= i_worker;
        end
    end

    // head word of the selected queue
    always_comb begin
        unique case (i_ctrl.qsel)
            tpjd_pkg::Q_HIGH:   head_word = r_rd_h;
            tpjd_pkg::Q_NORMAL: head_word = r_rd_n;
            default:            head_word = r_rd_l;
        endcase
    end

    // lowest idle worker whose mask overlaps the type
    assign mtype  = i_ctrl.match_in ? r_type : head_word[23:16];
    assign active = (r_wcount > 4'(WORKERS)) ? 4'(WORKERS) : r_wcount;
    always_comb begin
        for (int i = 0; i < WORKERS; i++) begin
            cand[i] = (4'(i) < active) && !r_busy[i] && ((r_masks[8*i +: 8] & mtype) != 8'd0);
        end
        found = 1'b0;
        win   = 3'd0;
        for (int i = WORKERS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                found = 1'b1;
                win   = 3'(i);
            end
        end
    end

    assign wr_sum = {1'b0, r_head[i_ctrl.qsel]} + (AW+1)'(r_cnt[i_ctrl.qsel]);
    assign wr_pos = (wr_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                    AW'(wr_sum - (AW+1)'(QUEUE_DEPTH)) : AW'(wr_sum);

    // queue memory writes and head reads
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push && i_ctrl.qsel == tpjd_pkg::Q_HIGH)   r_mem_h[wr_pos] <= {r_type, r_tag};
        if (i_ctrl.push && i_ctrl.qsel == tpjd_pkg::Q_NORMAL) r_mem_n[wr_pos] <= {r_type, r_tag};
        if (i_ctrl.push && i_ctrl.qsel == tpjd_pkg::Q_LOW)    r_mem_l[wr_pos] <= {r_type, r_tag};
        if (i_ctrl.rd) begin
            r_rd_h <= r_mem_h[r_head[tpjd_pkg::Q_HIGH]];
            r_rd_n <= r_mem_n[r_head[tpjd_pkg::Q_NORMAL]];
            r_rd_l <= r_mem_l[r_head[tpjd_pkg::Q_LOW]];
        end
    end

    // queue pointers and worker busy bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < 3; q++) begin
                r_head[q] <= '0;
                r_cnt[q]  <= '0;
            end
            r_busy <= '0;
        end else begin
            if (i_ctrl.push) r_cnt[i_ctrl.qsel] <= r_cnt[i_ctrl.qsel] + CW'(1);
            if (i_ctrl.pop) begin
                r_cnt[i_ctrl.qsel] <= r_cnt[i_ctrl.qsel] - CW'(1);
                r_head[i_ctrl.qsel] <= (r_head[i_ctrl.qsel] == AW'(QUEUE_DEPTH - 1)) ?
                                       '0 : r_head[i_ctrl.qsel] + AW'(1);
            end
            if ((i_ctrl.pop || i_ctrl.grant_in) && found) r_busy[win[$clog2(WORKERS > 1 ? WORKERS : 2)-1:0]] <= 1'b1;
            if (i_ctrl.release_w) r_busy[r_wk[$clog2(WORKERS > 1 ? WORKERS : 2)-1:0]] <= 1'b0;
        end
    end

    assign o_stat.kind    = r_kind;
    assign o_stat.prio    = r_prio;
    assign o_stat.found   = found;
    assign o_stat.q_empty = (r_cnt[i_ctrl.qsel] == '0);
    assign o_stat.q_full  = (r_cnt[i_ctrl.qsel] == CW'(QUEUE_DEPTH));
    assign o_stat.rel_ok  = (32'(r_wk) < WORKERS) && r_busy[r_wk[$clog2(WORKERS > 1 ? WORKERS : 2)-1:0]];

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_ctrl.emit;
        end
        o_status          <= i_ctrl.status;
        o_last            <= i_ctrl.last;
        o_assigned_worker <= !i_ctrl.use_worker ? 3'd0 :
                             (r_kind == tpjd_pkg::KIND_RELEASE) ? r_wk : win;
        o_dispatched_tag  <= !i_ctrl.use_tag ? 16'd0 :
                             i_ctrl.use_head ? head_word[15:0] : r_tag;
    end
endmodule

>>> rtl/typed_priority_job_dispatcher_top.sv
// Typed priority job dispatcher, top level.
// Submit and release: one result word per accepted item; busy until it has been shown.
// Tick: each head is read through the registered memory port (S_RD, S_WAIT, S_HEAD),
// high queue first; empty queues and blocked heads move on down, then the done word.
// Results are strobed one cycle each on o_valid; the receiver cannot stall.
// Synchronous active-low reset: queues empty, workers idle, 8 workers, all masks set.
`include "typed_priority_job_dispatcher_top_defines.svh"
module typed_priority_job_dispatcher_top #(
    parameter int QUEUE_DEPTH = 1024,
    parameter int WORKERS     = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_job_tag,
    input  logic [7:0]  i_job_type,
    input  logic [1:0]  i_priority_req,
    input  logic [2:0]  i_worker,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [2:0]  o_assigned_worker,
    output logic [15:0] o_dispatched_tag,
    output logic        o_last
);
    tpjd_pkg::t_ctrl ctrl;
    tpjd_pkg::t_stat stat;
    logic ctrl_busy;

    // controller
    tpjd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start && !busy),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (ctrl_busy)
    );

    // datapath
    tpjd_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .WORKERS(WORKERS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_kind            (i_kind),
        .i_job_tag         (i_job_tag),
        .i_job_type        (i_job_type),
        .i_priority_req    (i_priority_req),
        .i_worker          (i_worker),
        .i_ctrl            (ctrl),
        .o_stat            (stat),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_assigned_worker (o_assigned_worker),
        .o_dispatched_tag  (o_dispatched_tag),
        .o_last            (o_last)
    );

    // busy also covers the final result cycle
    assign busy = ctrl_busy || o_valid;

    // checks
    `TPJD_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_valid && o_last, !o_valid)
    `TPJD_ASSERT_IMPL(a_push_pop, i_clk, i_rst_n, ctrl.push, !ctrl.pop)
    `TPJD_ASSERT_IMPL(a_last_status, i_clk, i_rst_n, o_valid && !o_last, o_status == tpjd_pkg::ST_DISPATCHED)
endmodule

>>> tb/testbench.sv
// self-checking testbench for the typed priority job dispatcher
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH  = 1024;
    localparam int NWORKER = 8;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  worker;
        logic [15:0] tag;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [7:0]  jtype;
        logic [15:0] tag;
    } t_job;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [63:0] i_cfg_data;
    logic [1:0]  i_kind;
    logic [15:0] i_job_tag;
    logic [7:0]  i_job_type;
    logic [1:0]  i_priority_req;
    logic [2:0]  i_worker;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [2:0]  o_assigned_worker;
    logic [15:0] o_dispatched_tag;
    logic        o_last;

    // predictor state
    logic [3:0]  mdl_count;
    logic [63:0] mdl_masks;
    logic [NWORKER-1:0] mdl_busy;
    t_job        job_q [3][$];
    t_result     exp_words [$];
    int          error_count;
    bit          idling_on;

    typed_priority_job_dispatcher_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_kind(i_kind), .i_job_tag(i_job_tag), .i_job_type(i_job_type),
        .i_priority_req(i_priority_req), .i_worker(i_worker),
        .o_valid(o_valid), .o_status(o_status), .o_assigned_worker(o_assigned_worker),
        .o_dispatched_tag(o_dispatched_tag), .o_last(o_last)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #2000000;
        $display("FAIL typed_priority_job_dispatcher_top");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result exp_w;
        if (i_rst_n && o_valid) begin
            if (exp_words.size() == 0) begin
                report_mismatch("unexpected result word, status", o_status, -1);
            end else begin
                exp_w = exp_words.pop_front();
                if (o_status !== exp_w.status)
                    report_mismatch("status", o_status, exp_w.status);
                if (o_assigned_worker !== exp_w.worker)
                    report_mismatch("assigned_worker", o_assigned_worker, exp_w.worker);
                if (o_dispatched_tag !== exp_w.tag)
                    report_mismatch("dispatched_tag", o_dispatched_tag, exp_w.tag);
                if (o_last !== exp_w.last)
                    report_mismatch("last", o_last, exp_w.last);
            end
        end
    end

    // lowest idle worker whose mask overlaps the type, or -1
    function automatic int pick_worker(input logic [7:0] jtype);
        int n;
        n = (mdl_count > NWORKER) ? NWORKER : mdl_count;
        for (int i = 0; i < n; i++) begin
            if ((mdl_masks[8*i +: 8] & jtype) != 0 && !mdl_busy[i])
                return i;
        end
        return -1;
    endfunction

    function automatic void push_result(input logic [2:0] st, input logic [2:0] w,
                                        input logic [15:0] tag, input logic last);
        t_result r;
        r.status = st;
        r.worker = w;
        r.tag    = tag;
        r.last   = last;
        exp_words.push_back(r);
    endfunction

    // expected words for one accepted item
    function automatic void predict_dispatch(input logic [1:0] kind, input logic [15:0] tag,
                                             input logic [7:0] jtype, input logic [1:0] prio,
                                             input logic [2:0] wk);
        int w;
        int q;
        t_job j;
        if (kind == tpjd_pkg::KIND_SUBMIT) begin
            if (prio == tpjd_pkg::PRIO_HIGH) begin
                w = pick_worker(jtype);
                if (w >= 0) begin
                    mdl_busy[w] = 1'b1;
                    push_result(tpjd_pkg::ST_DISPATCHED, w[2:0], tag, 1'b1);
                    return;
                end
                q = tpjd_pkg::Q_HIGH;
            end else if (prio == tpjd_pkg::PRIO_LOW) begin
                q = tpjd_pkg::Q_LOW;
            end else begin
                q = tpjd_pkg::Q_NORMAL;
            end
            if (job_q[q].size() >= QDEPTH) begin
                push_result(tpjd_pkg::ST_DROPPED, 3'd0, tag, 1'b1);
            end else begin
                j.jtype = jtype;
                j.tag   = tag;
                job_q[q].push_back(j);
                push_result(tpjd_pkg::ST_QUEUED, 3'd0, tag, 1'b1);
            end
        end else if (kind == tpjd_pkg::KIND_TICK) begin
            foreach (job_q[qq]) begin
                q = tpjd_pkg::Q_HIGH - qq;
                while (job_q[q].size() > 0) begin
                    w = pick_worker(job_q[q][0].jtype);
                    if (w < 0) break;
                    mdl_busy[w] = 1'b1;
                    j = job_q[q].pop_front();
                    push_result(tpjd_pkg::ST_DISPATCHED, w[2:0], j.tag, 1'b0);
                end
            end
            push_result(tpjd_pkg::ST_TICK_DONE, 3'd0, 16'd0, 1'b1);
        end else if (kind == tpjd_pkg::KIND_RELEASE) begin
            if (mdl_busy[wk]) begin
                mdl_busy[wk] = 1'b0;
                push_result(tpjd_pkg::ST_RELEASED, wk, 16'd0, 1'b1);
            end else begin
                push_result(tpjd_pkg::ST_IGNORED, wk, 16'd0, 1'b1);
            end
        end
    endfunction

    // send one word and wait for it to be taken
    task automatic send_item(input logic [1:0] kind, input logic [15:0] tag,
                             input logic [7:0] jtype, input logic [1:0] prio,
                             input logic [2:0] wk);
        @(negedge i_clk);
        start          = 1'b1;
        i_kind         = kind;
        i_job_tag      = tag;
        i_job_type     = jtype;
        i_priority_req = prio;
        i_worker       = wk;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        predict_dispatch(kind, tag, jtype, prio, wk);
    endtask

    task automatic idle_gap();
        int n;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 14);
            repeat (n) begin
                @(negedge i_clk);
                start = 1'b0;
            end
        end
    endtask

    // wait until all words are out and the block has settled
    task automatic drain_results();
        @(negedge i_clk);
        start = 1'b0;
        while (exp_words.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] data);
        drain_results();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        if (idx == tpjd_pkg::CFG_WORKER_COUNT) mdl_count = data[3:0];
        else mdl_masks = data;
    endtask

    task automatic send_random();
        int r;
        logic [7:0] jt;
        r  = $urandom_range(0, 99);
        jt = 8'($urandom_range(1, 255));
        if (r < 45)
            send_item(tpjd_pkg::KIND_SUBMIT, 16'($urandom), jt,
                      2'($urandom_range(0, 3)), 3'd0);
        else if (r < 70)
            send_item(tpjd_pkg::KIND_TICK, 16'($urandom), 8'($urandom),
                      2'($urandom), 3'($urandom));
        else if (r < 95)
            send_item(tpjd_pkg::KIND_RELEASE, 16'($urandom), 8'($urandom),
                      2'($urandom), 3'($urandom_range(0, 7)));
        else
            send_item(2'd3, 16'($urandom), 8'($urandom), 2'($urandom), 3'($urandom));
    endtask

    // direct grants, queueing, ticks, releases and unused kind
    task automatic test_directed();
        send_item(tpjd_pkg::KIND_SUBMIT, 16'hFFFF, 8'hFF, tpjd_pkg::PRIO_HIGH, 3'd0);
        send_item(tpjd_pkg::KIND_SUBMIT, 16'h0000, 8'h80, tpjd_pkg::PRIO_HIGH, 3'd0);
        send_item(tpjd_pkg::KIND_SUBMIT, 16'h1234, 8'h01, tpjd_pkg::PRIO_LOW, 3'd0);
        send_item(tpjd_pkg::KIND_SUBMIT, 16'h5678, 8'h02, tpjd_pkg::PRIO_NORMAL, 3'd0);
        send_item(tpjd_pkg::KIND_SUBMIT, 16'h9ABC, 8'h04, 2'd3, 3'd0);
        send_item(tpjd_pkg::KIND_TICK, 16'h0, 8'h0, 2'd0, 3'd0);
        send_item(tpjd_pkg::KIND_RELEASE, 16'h0, 8'h0, 2'd0, 3'd0);
        send_item(tpjd_pkg::KIND_RELEASE, 16'h0, 8'h0, 2'd0, 3'd0);
        send_item(tpjd_pkg::KIND_RELEASE, 16'h0, 8'h0, 2'd0, 3'd7);
        send_item(2'd3, 16'hAAAA, 8'h55, 2'd3, 3'd5);
        // one worker only, taking a single type
        write_reg(tpjd_pkg::CFG_WORKER_COUNT, 64'd1);
        write_reg(tpjd_pkg::CFG_TYPE_MASKS, 64'hFFFF_FFFF_FFFF_FF10);
        send_item(tpjd_pkg::KIND_SUBMIT, 16'h0101, 8'h10, tpjd_pkg::PRIO_HIGH, 3'd0);
        send_item(tpjd_pkg::KIND_SUBMIT, 16'h0202, 8'h10, tpjd_pkg::PRIO_HIGH, 3'd0);
        send_item(tpjd_pkg::KIND_SUBMIT, 16'h0303, 8'hEF, tpjd_pkg::PRIO_NORMAL, 3'd0);
        send_item(tpjd_pkg::KIND_RELEASE, 16'h0, 8'h0, 2'd0, 3'd0);
        send_item(tpjd_pkg::KIND_TICK, 16'h0, 8'h0, 2'd0, 3'd0);
        // count above the worker total, then no workers at all
        write_reg(tpjd_pkg::CFG_WORKER_COUNT, 64'd15);
        send_item(tpjd_pkg::KIND_TICK, 16'h0, 8'h0, 2'd0, 3'd0);
        write_reg(tpjd_pkg::CFG_WORKER_COUNT, 64'd0);
        send_item(tpjd_pkg::KIND_SUBMIT, 16'h0404, 8'hFF, tpjd_pkg::PRIO_HIGH, 3'd0);
        send_item(tpjd_pkg::KIND_RELEASE, 16'h0, 8'h0, 2'd0, 3'd7);
        send_item(tpjd_pkg::KIND_TICK, 16'h0, 8'h0, 2'd0, 3'd0);
    endtask

    // random words across several register settings
    task automatic test_random();
        logic [3:0]  counts [4] = '{4'd8, 4'd3, 4'd1, 4'd15};
        logic [63:0] masks  [4];
        masks[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        masks[1] = {$urandom, $urandom};
        masks[2] = 64'd0;
        masks[3] = 64'h8040_2010_0804_0201;
        for (int p = 0; p < 4; p++) begin
            write_reg(tpjd_pkg::CFG_WORKER_COUNT, 64'(counts[p]));
            write_reg(tpjd_pkg::CFG_TYPE_MASKS, masks[p]);
            idling_on = (p < 3);
            for (int i = 0; i < 32; i++) begin
                send_random();
                idle_gap();
            end
        end
    endtask

    // a type-zero job blocks its queue, no workers leaves jobs queued
    task automatic test_blocking();
        write_reg(tpjd_pkg::CFG_WORKER_COUNT, 64'd8);
        write_reg(tpjd_pkg::CFG_TYPE_MASKS, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int w = 0; w < NWORKER; w++)
            send_item(tpjd_pkg::KIND_RELEASE, 16'h0, 8'h0, 2'd0, w[2:0]);
        send_item(tpjd_pkg::KIND_SUBMIT, 16'hBEEF, 8'h00, tpjd_pkg::PRIO_HIGH, 3'd0);
        send_item(tpjd_pkg::KIND_SUBMIT, 16'hCAFE, 8'h03, tpjd_pkg::PRIO_HIGH, 3'd0);
        send_item(tpjd_pkg::KIND_TICK, 16'h0, 8'h0, 2'd0, 3'd0);
        write_reg(tpjd_pkg::CFG_WORKER_COUNT, 64'd0);
        send_item(tpjd_pkg::KIND_SUBMIT, 16'hDEAD, 8'h01, tpjd_pkg::PRIO_LOW, 3'd0);
        write_reg(tpjd_pkg::CFG_WORKER_COUNT, 64'd8);
        send_item(tpjd_pkg::KIND_TICK, 16'h0, 8'h0, 2'd0, 3'd0);
    endtask

    initial begin
        error_count    = 0;
        idling_on      = 1'b1;
        mdl_count      = 4'd8;
        mdl_masks      = '1;
        mdl_busy       = '0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = 1'b0;
        i_cfg_data     = '0;
        i_kind         = '0;
        i_job_tag      = '0;
        i_job_type     = '0;
        i_priority_req = '0;
        i_worker       = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random();
        test_blocking();
        drain_results();
        if (error_count == 0) begin
            $display("PASS typed_priority_job_dispatcher_top");
        end else begin
            $display("FAIL typed_priority_job_dispatcher_top");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl
rtl/tpjd_pkg.sv
rtl/tpjd_ctrl.sv
rtl/tpjd_datapath.sv
rtl/typed_priority_job_dispatcher_top.sv
tb/testbench.sv
